// ===== hdl/bounded_stack_with_min_core_assert.svh =====
// Assertion macros shared by the bounded stack with minimum core.
`ifndef BOUNDED_STACK_WITH_MIN_CORE_ASSERT_SVH
`define BOUNDED_STACK_WITH_MIN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hdl/bsm_pkg.sv =====
// Types, constants and codes shared by the bounded stack with minimum core.
`timescale 1ns / 1ps

package bsm_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int FUNC_WIDTH = 2;
   localparam int STAT_WIDTH = 2;
   localparam int FILL_WIDTH = 5;
   localparam int ADDR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

   localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_MIN  = 2'd2
   } func_type;

   typedef enum logic [STAT_WIDTH-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_WORD_MAX,
      RES_READ,
      RES_MIN
   } res_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_POP_READ,
      S_MIN_FIRST,
      S_MIN_SCAN,
      S_MIN_END,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]        func;
      logic signed [DATA_WIDTH-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_value;
      logic [STAT_WIDTH-1:0]        status;
      logic                         is_empty;
      logic                         is_full;
      logic [FILL_WIDTH-1:0]        fill_count;
   } rsp_type;

   typedef struct packed {
      logic                  load_req;
      logic                  push_write;
      logic                  pop_read;
      logic                  scan_start;
      logic                  scan_next;
      logic                  min_load;
      logic                  min_cmp;
      logic                  res_load;
      res_sel_type           res_sel;
      logic [STAT_WIDTH-1:0] res_status;
      logic                  out_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic                  is_empty;
      logic                  is_full;
      logic                  scan_more;
   } dp_stat_type;

endpackage

// ===== hdl/bsm_ctrl.sv =====
// Controller state machine that sequences push, pop and minimum scans.
`timescale 1ns / 1ps

module bsm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bsm_pkg::dp_stat_type dp_stat,
   output bsm_pkg::cmd_type     cmd
);

   bsm_pkg::state_type state_ff;
   bsm_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         bsm_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = bsm_pkg::S_DECODE;
            end
         end
         bsm_pkg::S_DECODE: begin
            case (dp_stat.func)
               bsm_pkg::FUNC_PUSH: begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = bsm_pkg::RES_ZERO;
                  if (dp_stat.is_full) begin
                     cmd.res_status = bsm_pkg::STATUS_OVERFLOW;
                  end else begin
                     cmd.push_write = 1'b1;
                     cmd.res_status = bsm_pkg::STATUS_OK;
                  end
                  state_in = bsm_pkg::S_DONE;
               end
               bsm_pkg::FUNC_POP: begin
                  if (dp_stat.is_empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_sel    = bsm_pkg::RES_ZERO;
                     cmd.res_status = bsm_pkg::STATUS_EMPTY;
                     state_in       = bsm_pkg::S_DONE;
                  end else begin
                     cmd.pop_read = 1'b1;
                     state_in     = bsm_pkg::S_POP_READ;
                  end
               end
               bsm_pkg::FUNC_MIN: begin
                  if (dp_stat.is_empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_sel    = bsm_pkg::RES_WORD_MAX;
                     cmd.res_status = bsm_pkg::STATUS_EMPTY;
                     state_in       = bsm_pkg::S_DONE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = bsm_pkg::S_MIN_FIRST;
                  end
               end
               default: begin
                  // The unused operation code leaves the stack alone.
                  cmd.res_load   = 1'b1;
                  cmd.res_sel    = bsm_pkg::RES_ZERO;
                  cmd.res_status = bsm_pkg::STATUS_OK;
                  state_in       = bsm_pkg::S_DONE;
               end
            endcase
         end
         bsm_pkg::S_POP_READ: begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = bsm_pkg::RES_READ;
            cmd.res_status = bsm_pkg::STATUS_OK;
            state_in       = bsm_pkg::S_DONE;
         end
         bsm_pkg::S_MIN_FIRST: begin
            cmd.min_load = 1'b1;
            if (dp_stat.scan_more) begin
               cmd.scan_next = 1'b1;
               state_in      = bsm_pkg::S_MIN_SCAN;
            end else begin
               state_in = bsm_pkg::S_MIN_END;
            end
         end
         bsm_pkg::S_MIN_SCAN: begin
            cmd.min_cmp = 1'b1;
            if (dp_stat.scan_more) begin
               cmd.scan_next = 1'b1;
            end else begin
               state_in = bsm_pkg::S_MIN_END;
            end
         end
         bsm_pkg::S_MIN_END: begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = bsm_pkg::RES_MIN;
            cmd.res_status = bsm_pkg::STATUS_OK;
            state_in       = bsm_pkg::S_DONE;
         end
         bsm_pkg::S_DONE: begin
            // Wait here until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = bsm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsm_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != bsm_pkg::S_IDLE);

endmodule

// ===== hdl/bsm_datapath.sv =====
// Datapath: entry memory, fill count, minimum scan and output register.
`timescale 1ns / 1ps

module bsm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bsm_pkg::req_type     req_word,
   output bsm_pkg::rsp_type     rsp_word,
   input  bsm_pkg::cmd_type     cmd,
   output bsm_pkg::dp_stat_type dp_stat
);

   logic signed [bsm_pkg::DATA_WIDTH-1:0] entries_mem [bsm_pkg::DEPTH];

   bsm_pkg::req_type                      req_ff;
   logic [bsm_pkg::CNT_WIDTH-1:0]         count_ff;
   logic [bsm_pkg::CNT_WIDTH-1:0]         count_in;
   logic [bsm_pkg::CNT_WIDTH-1:0]         scan_idx_ff;
   logic [bsm_pkg::CNT_WIDTH-1:0]         scan_idx_in;
   logic signed [bsm_pkg::DATA_WIDTH-1:0] rd_data_ff;
   logic signed [bsm_pkg::DATA_WIDTH-1:0] min_ff;
   logic signed [bsm_pkg::DATA_WIDTH-1:0] min_in;
   logic signed [bsm_pkg::DATA_WIDTH-1:0] res_value_ff;
   logic signed [bsm_pkg::DATA_WIDTH-1:0] res_value_in;
   logic [bsm_pkg::STAT_WIDTH-1:0]        res_status_ff;
   bsm_pkg::rsp_type                      rsp_ff;
   bsm_pkg::rsp_type                      rsp_in;

   logic [bsm_pkg::CNT_WIDTH-1:0]         count_dec;
   logic [bsm_pkg::ADDR_WIDTH-1:0]        rd_addr;
   logic                                  rd_en;
   logic                                  is_empty;
   logic                                  is_full;

   assign count_dec = count_ff - bsm_pkg::CNT_WIDTH'(1);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == bsm_pkg::CNT_WIDTH'(bsm_pkg::DEPTH));
   assign rd_en     = cmd.pop_read | cmd.scan_start | cmd.scan_next;

   always_comb begin
      if (cmd.pop_read) begin
         rd_addr = count_dec[bsm_pkg::ADDR_WIDTH-1:0];
      end else if (cmd.scan_start) begin
         rd_addr = '0;
      end else begin
         rd_addr = scan_idx_ff[bsm_pkg::ADDR_WIDTH-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push_write) begin
         count_in = count_ff + bsm_pkg::CNT_WIDTH'(1);
      end else if (cmd.pop_read) begin
         count_in = count_dec;
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.scan_start) begin
         scan_idx_in = bsm_pkg::CNT_WIDTH'(1);
      end else if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + bsm_pkg::CNT_WIDTH'(1);
      end
   end

   always_comb begin
      min_in = min_ff;
      if (cmd.min_load) begin
         min_in = rd_data_ff;
      end else if (cmd.min_cmp && (rd_data_ff < min_ff)) begin
         min_in = rd_data_ff;
      end
   end

   always_comb begin
      case (cmd.res_sel)
         bsm_pkg::RES_ZERO:     res_value_in = '0;
         bsm_pkg::RES_WORD_MAX: res_value_in = bsm_pkg::WORD_MAX;
         bsm_pkg::RES_READ:     res_value_in = rd_data_ff;
         bsm_pkg::RES_MIN:      res_value_in = min_ff;
         default:               res_value_in = '0;
      endcase
   end

   // Flags and count come from the count after the operation has taken effect.
   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.result_value = res_value_ff;
      rsp_in.status       = res_status_ff;
      rsp_in.is_empty     = is_empty;
      rsp_in.is_full      = is_full;
      rsp_in.fill_count   = bsm_pkg::FILL_WIDTH'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_write) begin
         entries_mem[count_ff[bsm_pkg::ADDR_WIDTH-1:0]] <= req_ff.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= entries_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
      if (cmd.res_load) begin
         res_value_ff  <= res_value_in;
         res_status_ff <= cmd.res_status;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
      scan_idx_ff <= scan_idx_in;
      min_ff      <= min_in;
   end

   assign rsp_word          = rsp_ff;
   assign dp_stat.func      = req_ff.func;
   assign dp_stat.is_empty  = is_empty;
   assign dp_stat.is_full   = is_full;
   assign dp_stat.scan_more = (scan_idx_ff < count_ff);

endmodule

// ===== hdl/bounded_stack_with_min_core.sv =====
// Top level of the bounded stack with minimum query.
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_stall   req_word (func, push_value)
//   rsp      out        rsp_valid/rsp_stall   rsp_word (result, status, flags, count)
//
// A push, a rejected push, an empty pop or query, or the unused code passes through the
// decode and done states; a pop adds the pop-read state for the registered memory read.
// A minimum query over n entries makes one memory read and compare per entry.
// Reset clears the fill count and the handshake state; entry contents are left as they are.
// A finished word waits in the output register; a new word is taken while it is stalled,
// and that word's result waits in the controller until the output register frees up.
`timescale 1ns / 1ps

`include "bounded_stack_with_min_core_assert.svh"

module bounded_stack_with_min_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsm_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsm_pkg::rsp_type rsp_word
);

   bsm_pkg::cmd_type     cmd;
   bsm_pkg::dp_stat_type dp_stat;

   bsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   bsm_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .rsp_word (rsp_word),
      .cmd      (cmd),
      .dp_stat  (dp_stat)
   );

   `BSM_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `BSM_ASSERT_SAME(a_out_load_free, cmd.out_load, !(rsp_valid && rsp_stall))
   `BSM_ASSERT_SAME(a_flags_exclusive, dp_stat.is_empty, !dp_stat.is_full)
   `BSM_ASSERT_SAME(a_push_not_full, cmd.push_write, !dp_stat.is_full)

endmodule
